### src/rti_pkg.sv
package rti_pkg;

    // Fixed field widths of the block.
    localparam int COORD_W    = 32;
    localparam int DIST_W     = 31;
    localparam int NORM_W     = 16;
    localparam int CFG_ADDR_W = 3;

    // Internal exact-arithmetic widths.
    localparam int EDGE_W     = 33;                 // vertex differences
    localparam int PAIR_W     = 2 * EDGE_W;         // one cross-product term
    localparam int VEC_W      = 67;                 // cross-product components
    localparam int PROD_W     = EDGE_W + VEC_W;     // one dot-product term
    localparam int DOT_W      = 104;                // dot products with headroom
    localparam int NSQ_W      = 2 * VEC_W;          // squared normal component
    localparam int NN_W       = 136;                // squared normal length
    localparam int NORM_SHIFT = 28;                 // 2 * fractional bits of Q2.14
    localparam int NNUM_W     = NSQ_W + NORM_SHIFT;
    localparam int QUO_W      = 31;                 // quotient bits of every divider
    localparam int SQRT_IN_W  = 29;
    localparam int SQRT_OUT_W = 15;
    localparam int MUL_LW     = 32;                 // limb width of the wide multiplier

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5,
        REG_MAX_DIST = 3'd6
    } cfg_reg_t;

    // Per-item decision flags that ride alongside the long divide pipes.
    typedef struct packed {
        logic       pass;
        logic       flip;
        logic [2:0] nneg;
    } tri_flags_t;

endpackage

### src/rti_mul.sv
module rti_mul #(
    parameter int AW = 33,
    parameter int BW = 67
) (
    input  logic                 clk,
    input  logic signed [AW-1:0] a,
    input  logic signed [BW-1:0] b,
    output logic signed [AW+BW-1:0] p
);
    import rti_pkg::*;

    localparam int NA = (AW + MUL_LW - 1) / MUL_LW;
    localparam int NB = (BW + MUL_LW - 1) / MUL_LW;

    logic signed [MUL_LW:0]       al [NA];
    logic signed [MUL_LW:0]       bl [NB];
    logic signed [2*MUL_LW+1:0]   pp_reg [NA][NB];
    logic signed [AW+BW-1:0]      sum_c;
    logic signed [AW+BW-1:0]      p_reg;

    // Split the operands into limbs: lower limbs unsigned, top limb signed.
    for (genvar k = 0; k < NA; k++) begin : g_alimb
        if (k < NA - 1) begin : g_low
            assign al[k] = {1'b0, a[k*MUL_LW +: MUL_LW]};
        end else begin : g_top
            assign al[k] = (MUL_LW+1)'($signed(a[AW-1:k*MUL_LW]));
        end
    end
    for (genvar k = 0; k < NB; k++) begin : g_blimb
        if (k < NB - 1) begin : g_low
            assign bl[k] = {1'b0, b[k*MUL_LW +: MUL_LW]};
        end else begin : g_top
            assign bl[k] = (MUL_LW+1)'($signed(b[BW-1:k*MUL_LW]));
        end
    end

    // First stage: limb partial products.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                pp_reg[i][j] <= al[i] * bl[j];
            end
        end
    end

    // Second stage: weighted sum of the partial products.
    always_comb
    begin
        sum_c = '0;
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                sum_c = sum_c + ((AW+BW)'(pp_reg[i][j]) <<< (MUL_LW * (i + j)));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= sum_c;
    end

    assign p = p_reg;

endmodule

### src/rti_div.sv
module rti_div #(
    parameter int NW = 118,
    parameter int DW = 104,
    parameter int QW = 31
) (
    input  logic          clk,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo
);
    import rti_pkg::*;

    localparam int W = (NW > DW + QW) ? NW : DW + QW;

    logic [W-1:0]  rem_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [QW-1:0] quo_reg [QW];

    // One quotient bit per stage, most significant first.  The caller
    // guarantees the quotient fits in QW bits.
    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [W-1:0]  rem_prev;
        logic [DW-1:0] den_prev;
        logic [QW-1:0] quo_prev;
        logic [W-1:0]  den_sh;

        if (k == 0) begin : g_first
            assign rem_prev = W'(num);
            assign den_prev = den;
            assign quo_prev = '0;
        end else begin : g_next
            assign rem_prev = rem_reg[k-1];
            assign den_prev = den_reg[k-1];
            assign quo_prev = quo_reg[k-1];
        end

        assign den_sh = W'(den_prev) << (QW - 1 - k);

        always_ff @(posedge clk)
        begin
            den_reg[k] <= den_prev;
            if (rem_prev >= den_sh)
            begin
                rem_reg[k] <= rem_prev - den_sh;
                quo_reg[k] <= quo_prev | (QW'(1) << (QW - 1 - k));
            end
            else
            begin
                rem_reg[k] <= rem_prev;
                quo_reg[k] <= quo_prev;
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

### src/rti_sqrt.sv
module rti_sqrt #(
    parameter int IW = 29
) (
    input  logic                      clk,
    input  logic [IW-1:0]             x,
    output logic [(IW+1)/2-1:0]       root
);
    import rti_pkg::*;

    localparam int N  = (IW + 1) / 2;
    localparam int XW = IW + 1;

    logic [XW-1:0] x_reg [N];
    logic [XW-1:0] r_reg [N];

    // Digit-by-digit integer square root, one result bit per stage.
    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [XW-1:0] x_prev;
        logic [XW-1:0] r_prev;
        logic [XW-1:0] bit_val;
        logic [XW-1:0] trial;

        if (k == 0) begin : g_first
            assign x_prev = XW'(x);
            assign r_prev = '0;
        end else begin : g_next
            assign x_prev = x_reg[k-1];
            assign r_prev = r_reg[k-1];
        end

        assign bit_val = XW'(1) << (2 * (N - 1 - k));
        assign trial   = r_prev + bit_val;

        always_ff @(posedge clk)
        begin
            if (x_prev >= trial)
            begin
                x_reg[k] <= x_prev - trial;
                r_reg[k] <= (r_prev >> 1) + bit_val;
            end
            else
            begin
                x_reg[k] <= x_prev;
                r_reg[k] <= r_prev >> 1;
            end
        end
    end

    assign root = r_reg[N-1][N-1:0];

endmodule

### src/rti_delay.sv
module rti_delay #(
    parameter int W = 8,
    parameter int N = 4
) (
    input  logic         clk,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);
    logic [W-1:0] sr_reg [N];

    // Plain register chain that keeps side data aligned with a long pipe.
    always_ff @(posedge clk)
    begin
        sr_reg[0] <= din;
        for (int k = 1; k < N; k++)
        begin
            sr_reg[k] <= sr_reg[k-1];
        end
    end

    assign dout = sr_reg[N-1];

endmodule

### src/ray_triangle_intersect_unit.sv
// Each start transfer that is taken gives one done strobe with its result.
// Throughput: one triangle per cycle; busy is always low.
// The depth is set by the 31-step normal divide pipes and the 15-step square root after them.
// Reset (rst_n low, asynchronous) clears all in-flight valid bits and loads the
// ray registers with origin 0, direction (0, 0, 1.0) and the largest distance.
// Each result is shown for exactly one cycle; the receiver cannot stall it.
module ray_triangle_intersect_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    output logic                                  done,
    input  logic                                  cfg_we,
    input  logic [rti_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [rti_pkg::COORD_W-1:0]           cfg_wdata,
    input  logic signed [rti_pkg::COORD_W-1:0]    v0_x,
    input  logic signed [rti_pkg::COORD_W-1:0]    v0_y,
    input  logic signed [rti_pkg::COORD_W-1:0]    v0_z,
    input  logic signed [rti_pkg::COORD_W-1:0]    v1_x,
    input  logic signed [rti_pkg::COORD_W-1:0]    v1_y,
    input  logic signed [rti_pkg::COORD_W-1:0]    v1_z,
    input  logic signed [rti_pkg::COORD_W-1:0]    v2_x,
    input  logic signed [rti_pkg::COORD_W-1:0]    v2_y,
    input  logic signed [rti_pkg::COORD_W-1:0]    v2_z,
    output logic                                  hit,
    output logic [rti_pkg::DIST_W-1:0]            distance,
    output logic signed [rti_pkg::COORD_W-1:0]    point_x,
    output logic signed [rti_pkg::COORD_W-1:0]    point_y,
    output logic signed [rti_pkg::COORD_W-1:0]    point_z,
    output logic signed [rti_pkg::NORM_W-1:0]     normal_x,
    output logic signed [rti_pkg::NORM_W-1:0]     normal_y,
    output logic signed [rti_pkg::NORM_W-1:0]     normal_z
);
    import rti_pkg::*;

    localparam int LAT     = 55;
    localparam int NT_W    = DOT_W + FRAC_BITS;
    localparam int OVF_W   = DOT_W + QUO_W;
    localparam int LIM_W   = COORD_W + DOT_W;
    localparam int PM_W    = 2 * COORD_W;
    localparam int PT_W    = PM_W + 1;
    localparam int BUND_W  = 1 + DIST_W + 3 * COORD_W;
    localparam int FLAGS_W = $bits(tri_flags_t);
    localparam int NXT [3] = '{1, 2, 0};
    localparam int PRV [3] = '{2, 0, 1};
    localparam logic [DOT_W-1:0] EPS_LIM =
        DOT_W'((((128'd1 << (3 * FRAC_BITS)) - 128'd1) / 128'd10000) + 128'd1);
    localparam logic signed [PT_W-1:0] SAT_MAX = PT_W'(64'sh7FFF_FFFF);
    localparam logic signed [PT_W-1:0] SAT_MIN = -PT_W'(64'sh8000_0000);
    localparam logic signed [NORM_W-1:0] NORM_ONE = NORM_W'(1 << (NORM_SHIFT / 2));

    // Ray registers.
    logic signed [COORD_W-1:0] org_reg [3];
    logic signed [COORD_W-1:0] dir_reg [3];
    logic [DIST_W-1:0]         max_dist_reg;
    logic signed [COORD_W-1:0] max_sgn;

    logic [LAT-1:0] vld_reg;

    logic signed [COORD_W-1:0] p0 [3];
    logic signed [COORD_W-1:0] p1 [3];
    logic signed [COORD_W-1:0] p2 [3];
    logic signed [EDGE_W-1:0]  dir33 [3];

    logic signed [EDGE_W-1:0] e1_s1_reg [3];
    logic signed [EDGE_W-1:0] e2_s1_reg [3];
    logic signed [EDGE_W-1:0] sv_s1_reg [3];
    logic signed [EDGE_W-1:0] e1_s2_reg [3];
    logic signed [EDGE_W-1:0] e2_s2_reg [3];
    logic signed [EDGE_W-1:0] sv_s2_reg [3];
    logic signed [EDGE_W-1:0] e1_s3_reg [3];
    logic signed [EDGE_W-1:0] e2_s3_reg [3];
    logic signed [EDGE_W-1:0] sv_s3_reg [3];

    logic signed [PAIR_W-1:0] ha_s2_reg [3];
    logic signed [PAIR_W-1:0] hb_s2_reg [3];
    logic signed [PAIR_W-1:0] qa_s2_reg [3];
    logic signed [PAIR_W-1:0] qb_s2_reg [3];
    logic signed [PAIR_W-1:0] na_s2_reg [3];
    logic signed [PAIR_W-1:0] nb_s2_reg [3];

    logic signed [VEC_W-1:0] h_s3_reg [3];
    logic signed [VEC_W-1:0] q_s3_reg [3];
    logic signed [VEC_W-1:0] n_s3_reg [3];

    logic signed [PROD_W-1:0] pa_s5 [3];
    logic signed [PROD_W-1:0] pu_s5 [3];
    logic signed [PROD_W-1:0] pv_s5 [3];
    logic signed [PROD_W-1:0] pt_s5 [3];
    logic signed [NSQ_W-1:0]  pn_s5 [3];
    logic [2:0]               nneg_s3;
    logic [2:0]               nneg_s5;

    logic signed [DOT_W-1:0] a_s6_reg;
    logic signed [DOT_W-1:0] u_s6_reg;
    logic signed [DOT_W-1:0] v_s6_reg;
    logic signed [DOT_W-1:0] t_s6_reg;
    logic [NN_W-1:0]         nn_s6_reg;
    logic [NSQ_W-1:0]        nsq_s6_reg [3];
    logic [2:0]              nneg_s6_reg;

    logic                    flip_s7_reg;
    logic signed [DOT_W-1:0] absa_s7_reg;
    logic signed [DOT_W-1:0] u_s7_reg;
    logic signed [DOT_W-1:0] v_s7_reg;
    logic signed [DOT_W-1:0] t_s7_reg;
    logic [NN_W-1:0]         nn_s7_reg;
    logic [NSQ_W-1:0]        nsq_s7_reg [3];
    logic [2:0]              nneg_s7_reg;

    logic                    pass_s7;
    logic [OVF_W-1:0]        t_sh;
    logic [OVF_W-1:0]        a_sh;

    tri_flags_t        flags_s8_reg;
    logic [NT_W-1:0]   tnum_s8_reg;
    logic [DOT_W-1:0]  absa_s8_reg;
    logic [NN_W-1:0]   nn_s8_reg;
    logic [NNUM_W-1:0] nnum_s8_reg [3];

    logic signed [LIM_W-1:0] mla_s8;
    logic signed [LIM_W-1:0] lim_s8;
    logic                    tle_s8;
    tri_flags_t              flags_s8;

    logic [QUO_W-1:0]      tq_s39;
    logic [QUO_W-1:0]      nq_s39 [3];
    logic [FLAGS_W-1:0]    flags_s39_bits;
    tri_flags_t            flags_s39;
    logic [FLAGS_W-1:0]    flags_s54_bits;
    tri_flags_t            flags_s54;
    logic [SQRT_OUT_W-1:0] nmag_s54 [3];

    logic                     hit_s40_reg;
    logic [DIST_W-1:0]        tq_s40_reg;
    logic signed [PM_W-1:0]   pm_s40_reg [3];

    logic                      hit_s41_reg;
    logic [DIST_W-1:0]         tq_s41_reg;
    logic signed [COORD_W-1:0] pt_s41_reg [3];
    logic signed [PT_W-1:0]    psum [3];

    logic [BUND_W-1:0]         bund_s54;
    logic                      hit_s54;
    logic [DIST_W-1:0]         tq_s54;
    logic signed [COORD_W-1:0] pt_s54 [3];

    logic                      hit_reg;
    logic [DIST_W-1:0]         distance_reg;
    logic signed [COORD_W-1:0] point_reg [3];
    logic signed [NORM_W-1:0]  normal_reg [3];

    // Every cycle can take a triangle.
    assign busy = 1'b0;

    assign p0 = '{v0_x, v0_y, v0_z};
    assign p1 = '{v1_x, v1_y, v1_z};
    assign p2 = '{v2_x, v2_y, v2_z};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dir33[i] = EDGE_W'(dir_reg[i]);
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg      <= '{default: '0};
            dir_reg      <= '{COORD_W'(0), COORD_W'(0), COORD_W'(1 << FRAC_BITS)};
            max_dist_reg <= '1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_ORIGIN_X: org_reg[0]   <= cfg_wdata;
                REG_ORIGIN_Y: org_reg[1]   <= cfg_wdata;
                REG_ORIGIN_Z: org_reg[2]   <= cfg_wdata;
                REG_DIR_X:    dir_reg[0]   <= cfg_wdata;
                REG_DIR_Y:    dir_reg[1]   <= cfg_wdata;
                REG_DIR_Z:    dir_reg[2]   <= cfg_wdata;
                REG_MAX_DIST: max_dist_reg <= cfg_wdata[DIST_W-1:0];
                default:      ;
            endcase
        end
    end

    assign max_sgn = $signed({1'b0, max_dist_reg});

    // Valid bits travel down the pipe beside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], start & ~busy};
        end
    end

    // Stages 1 to 3: edges, cross-product terms, cross products.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            e1_s1_reg[i] <= EDGE_W'(p1[i]) - EDGE_W'(p0[i]);
            e2_s1_reg[i] <= EDGE_W'(p2[i]) - EDGE_W'(p0[i]);
            sv_s1_reg[i] <= EDGE_W'(org_reg[i]) - EDGE_W'(p0[i]);

            ha_s2_reg[i] <= dir33[NXT[i]] * e2_s1_reg[PRV[i]];
            hb_s2_reg[i] <= dir33[PRV[i]] * e2_s1_reg[NXT[i]];
            qa_s2_reg[i] <= sv_s1_reg[NXT[i]] * e1_s1_reg[PRV[i]];
            qb_s2_reg[i] <= sv_s1_reg[PRV[i]] * e1_s1_reg[NXT[i]];
            na_s2_reg[i] <= e1_s1_reg[NXT[i]] * e2_s1_reg[PRV[i]];
            nb_s2_reg[i] <= e1_s1_reg[PRV[i]] * e2_s1_reg[NXT[i]];
            e1_s2_reg[i] <= e1_s1_reg[i];
            e2_s2_reg[i] <= e2_s1_reg[i];
            sv_s2_reg[i] <= sv_s1_reg[i];

            h_s3_reg[i]  <= VEC_W'(ha_s2_reg[i]) - VEC_W'(hb_s2_reg[i]);
            q_s3_reg[i]  <= VEC_W'(qa_s2_reg[i]) - VEC_W'(qb_s2_reg[i]);
            n_s3_reg[i]  <= VEC_W'(na_s2_reg[i]) - VEC_W'(nb_s2_reg[i]);
            e1_s3_reg[i] <= e1_s2_reg[i];
            e2_s3_reg[i] <= e2_s2_reg[i];
            sv_s3_reg[i] <= sv_s2_reg[i];
        end
    end

    // Stages 4 and 5: dot-product terms and squared normal components.
    for (genvar i = 0; i < 3; i++) begin : g_mul
        rti_mul #(.AW(EDGE_W), .BW(VEC_W)) u_mul_a (
            .clk (clk), .a (e1_s3_reg[i]), .b (h_s3_reg[i]), .p (pa_s5[i])
        );
        rti_mul #(.AW(EDGE_W), .BW(VEC_W)) u_mul_u (
            .clk (clk), .a (sv_s3_reg[i]), .b (h_s3_reg[i]), .p (pu_s5[i])
        );
        rti_mul #(.AW(EDGE_W), .BW(VEC_W)) u_mul_v (
            .clk (clk), .a (dir33[i]), .b (q_s3_reg[i]), .p (pv_s5[i])
        );
        rti_mul #(.AW(EDGE_W), .BW(VEC_W)) u_mul_t (
            .clk (clk), .a (e2_s3_reg[i]), .b (q_s3_reg[i]), .p (pt_s5[i])
        );
        rti_mul #(.AW(VEC_W), .BW(VEC_W)) u_mul_n (
            .clk (clk), .a (n_s3_reg[i]), .b (n_s3_reg[i]), .p (pn_s5[i])
        );
        assign nneg_s3[i] = n_s3_reg[i][VEC_W-1];
    end

    rti_delay #(.W(3), .N(2)) u_dly_nneg (
        .clk (clk), .din (nneg_s3), .dout (nneg_s5)
    );

    // Stage 6: dot-product sums.  Stage 7: orient by the determinant sign.
    always_ff @(posedge clk)
    begin
        a_s6_reg    <= DOT_W'(pa_s5[0]) + DOT_W'(pa_s5[1]) + DOT_W'(pa_s5[2]);
        u_s6_reg    <= DOT_W'(pu_s5[0]) + DOT_W'(pu_s5[1]) + DOT_W'(pu_s5[2]);
        v_s6_reg    <= DOT_W'(pv_s5[0]) + DOT_W'(pv_s5[1]) + DOT_W'(pv_s5[2]);
        t_s6_reg    <= DOT_W'(pt_s5[0]) + DOT_W'(pt_s5[1]) + DOT_W'(pt_s5[2]);
        nn_s6_reg   <= NN_W'($unsigned(pn_s5[0])) + NN_W'($unsigned(pn_s5[1]))
                     + NN_W'($unsigned(pn_s5[2]));
        nneg_s6_reg <= nneg_s5;
        for (int i = 0; i < 3; i++)
        begin
            nsq_s6_reg[i] <= $unsigned(pn_s5[i]);
        end

        flip_s7_reg <= a_s6_reg[DOT_W-1];
        absa_s7_reg <= a_s6_reg[DOT_W-1] ? -a_s6_reg : a_s6_reg;
        u_s7_reg    <= a_s6_reg[DOT_W-1] ? -u_s6_reg : u_s6_reg;
        v_s7_reg    <= a_s6_reg[DOT_W-1] ? -v_s6_reg : v_s6_reg;
        t_s7_reg    <= a_s6_reg[DOT_W-1] ? -t_s6_reg : t_s6_reg;
        nn_s7_reg   <= nn_s6_reg;
        nneg_s7_reg <= nneg_s6_reg;
        for (int i = 0; i < 3; i++)
        begin
            nsq_s7_reg[i] <= nsq_s6_reg[i];
        end
    end

    // Stages 7 and 8: max distance times the signed determinant, for the
    // exact distance limit test.
    rti_mul #(.AW(COORD_W), .BW(DOT_W)) u_mul_lim (
        .clk (clk), .a (max_sgn), .b (a_s6_reg), .p (mla_s8)
    );

    // Stage 8: range tests.  The last test also keeps the distance quotient
    // below 2^31 so the divide pipe cannot overflow.
    assign t_sh = OVF_W'($unsigned(t_s7_reg)) << FRAC_BITS;
    assign a_sh = OVF_W'($unsigned(absa_s7_reg)) << QUO_W;

    assign pass_s7 = ($unsigned(absa_s7_reg) >= EPS_LIM)
                  && !u_s7_reg[DOT_W-1] && (u_s7_reg <= absa_s7_reg)
                  && !v_s7_reg[DOT_W-1] && ((u_s7_reg + v_s7_reg) <= absa_s7_reg)
                  && !t_s7_reg[DOT_W-1] && (t_sh < a_sh);

    always_ff @(posedge clk)
    begin
        flags_s8_reg.pass <= pass_s7;
        flags_s8_reg.flip <= flip_s7_reg;
        flags_s8_reg.nneg <= nneg_s7_reg;
        tnum_s8_reg       <= NT_W'($unsigned(t_s7_reg)) << FRAC_BITS;
        absa_s8_reg       <= $unsigned(absa_s7_reg);
        nn_s8_reg         <= nn_s7_reg;
        for (int i = 0; i < 3; i++)
        begin
            nnum_s8_reg[i] <= NNUM_W'(nsq_s7_reg[i]) << NORM_SHIFT;
        end
    end

    // The scaled distance must not exceed max distance times |det|.
    assign lim_s8 = flags_s8_reg.flip ? -mla_s8 : mla_s8;
    assign tle_s8 = $signed(LIM_W'(tnum_s8_reg)) <= lim_s8;

    always_comb
    begin
        flags_s8      = flags_s8_reg;
        flags_s8.pass = flags_s8_reg.pass & tle_s8;
    end

    // Stages 9 to 39: distance and normal-component divides.
    rti_div #(.NW(NT_W), .DW(DOT_W), .QW(QUO_W)) u_div_t (
        .clk (clk), .num (tnum_s8_reg), .den (absa_s8_reg), .quo (tq_s39)
    );

    for (genvar i = 0; i < 3; i++) begin : g_norm
        rti_div #(.NW(NNUM_W), .DW(NN_W), .QW(QUO_W)) u_div_n (
            .clk (clk), .num (nnum_s8_reg[i]), .den (nn_s8_reg), .quo (nq_s39[i])
        );
        // Stages 40 to 54: magnitude of each normal component.
        rti_sqrt #(.IW(SQRT_IN_W)) u_sqrt (
            .clk (clk), .x (nq_s39[i][SQRT_IN_W-1:0]), .root (nmag_s54[i])
        );
    end

    rti_delay #(.W(FLAGS_W), .N(QUO_W)) u_dly_flags_a (
        .clk (clk), .din (flags_s8), .dout (flags_s39_bits)
    );
    assign flags_s39 = tri_flags_t'(flags_s39_bits);

    rti_delay #(.W(FLAGS_W), .N(SQRT_OUT_W)) u_dly_flags_b (
        .clk (clk), .din (flags_s39_bits), .dout (flags_s54_bits)
    );
    assign flags_s54 = tri_flags_t'(flags_s54_bits);

    // Stages 40 and 41: hit point, floor-shifted and saturated.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            psum[i] = PT_W'(pm_s40_reg[i] >>> FRAC_BITS) + PT_W'(org_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        hit_s40_reg <= flags_s39.pass;
        tq_s40_reg  <= tq_s39;
        for (int i = 0; i < 3; i++)
        begin
            pm_s40_reg[i] <= $signed({1'b0, tq_s39}) * dir_reg[i];
        end

        hit_s41_reg <= hit_s40_reg;
        tq_s41_reg  <= tq_s40_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (psum[i] > SAT_MAX)
            begin
                pt_s41_reg[i] <= SAT_MAX[COORD_W-1:0];
            end
            else if (psum[i] < SAT_MIN)
            begin
                pt_s41_reg[i] <= SAT_MIN[COORD_W-1:0];
            end
            else
            begin
                pt_s41_reg[i] <= psum[i][COORD_W-1:0];
            end
        end
    end

    rti_delay #(.W(BUND_W), .N(13)) u_dly_point (
        .clk  (clk),
        .din  ({hit_s41_reg, tq_s41_reg, pt_s41_reg[0], pt_s41_reg[1], pt_s41_reg[2]}),
        .dout (bund_s54)
    );
    assign {hit_s54, tq_s54, pt_s54[0], pt_s54[1], pt_s54[2]} = bund_s54;

    // Stage 55: result register; a miss shows all zeros.
    always_ff @(posedge clk)
    begin
        hit_reg      <= hit_s54;
        distance_reg <= hit_s54 ? tq_s54 : '0;
        for (int i = 0; i < 3; i++)
        begin
            point_reg[i] <= hit_s54 ? pt_s54[i] : '0;
            if (!hit_s54)
            begin
                normal_reg[i] <= '0;
            end
            else if (flags_s54.nneg[i] != flags_s54.flip)
            begin
                normal_reg[i] <= -NORM_W'(nmag_s54[i]);
            end
            else
            begin
                normal_reg[i] <= NORM_W'(nmag_s54[i]);
            end
        end
    end

    assign done     = vld_reg[LAT-1];
    assign hit      = hit_reg;
    assign distance = distance_reg;
    assign point_x  = point_reg[0];
    assign point_y  = point_reg[1];
    assign point_z  = point_reg[2];
    assign normal_x = normal_reg[0];
    assign normal_y = normal_reg[1];
    assign normal_z = normal_reg[2];

    // Every accepted triangle produces its result a fixed time later.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result strobe missing after fixed latency");

    // A miss carries no distance, point or normal.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (distance == '0 && point_x == '0 && point_y == '0
                            && point_z == '0 && normal_x == '0 && normal_y == '0
                            && normal_z == '0))
        else $error("miss result carries nonzero fields");

    // A hit never lies beyond the configured range.
    a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (distance <= max_dist_reg))
        else $error("hit distance beyond max distance");

    // Normal components stay within one unit.
    a_norm_unit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (normal_x <= NORM_ONE && normal_x >= -NORM_ONE
                           && normal_y <= NORM_ONE && normal_y >= -NORM_ONE
                           && normal_z <= NORM_ONE && normal_z >= -NORM_ONE))
        else $error("normal component exceeds unit length");

endmodule

### tb/sv/ray_triangle_intersect_unit_tb.sv
module ray_triangle_intersect_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rti_pkg::*;

    localparam int FRAC       = 16;
    localparam int ONE        = 1 << FRAC;
    localparam int DRAIN      = 70;
    localparam int CYCLE_CAP  = 200000;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;

    typedef logic signed [255:0] wide_t;

    typedef enum logic { OP_TRI, OP_CFG } op_kind_t;

    typedef struct {
        logic signed [COORD_W-1:0] c [9];
    } triangle_t;

    typedef struct {
        op_kind_t                 kind;
        logic [CFG_ADDR_W-1:0]    addr;
        logic [COORD_W-1:0]       data;
        triangle_t                facet;
    } op_t;

    typedef struct {
        logic                      hit;
        logic [DIST_W-1:0]         tdist;
        logic signed [COORD_W-1:0] point [3];
        logic signed [NORM_W-1:0]  normal [3];
    } ray_hit_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic                      done;
    logic                      cfg_we;
    logic [CFG_ADDR_W-1:0]     cfg_addr;
    logic [COORD_W-1:0]        cfg_wdata;
    logic signed [COORD_W-1:0] vtx [9];
    logic                      hit;
    logic [DIST_W-1:0]         distance;
    logic signed [COORD_W-1:0] point_x, point_y, point_z;
    logic signed [NORM_W-1:0]  normal_x, normal_y, normal_z;

    // Ray registers as the block should hold them.
    logic signed [COORD_W-1:0] ray_org [3];
    logic signed [COORD_W-1:0] ray_dir [3];
    logic [DIST_W-1:0]         ray_max;

    op_t       pending_ops [$];
    ray_hit_t  expected_hits [$];
    triangle_t cur_tri;
    int        mismatches;
    int        cycle_count;
    bit        stimulus_done;

    ray_triangle_intersect_unit #(.FRAC_BITS(FRAC)) uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .v0_x(vtx[0]), .v0_y(vtx[1]), .v0_z(vtx[2]),
        .v1_x(vtx[3]), .v1_y(vtx[4]), .v1_z(vtx[5]),
        .v2_x(vtx[6]), .v2_y(vtx[7]), .v2_z(vtx[8]),
        .hit(hit), .distance(distance),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z)
    );

    // Clock and a single reset at the start.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic wide_t cross_c(input wide_t x1, input wide_t x2,
                                      input wide_t y1, input wide_t y2);
        return x1 * y2 - x2 * y1;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Exact Moller-Trumbore test of one triangle against the current ray.
    function automatic ray_hit_t trace_triangle(input triangle_t tr);
        wide_t    dd [3], sv [3], e1 [3], e2 [3], h [3], q [3], n [3];
        wide_t    p0, p1, p2, ov;
        wide_t    a, absa, u, v, t, mx, nn, pp, s, num, quo, cs;
        wide_t    sat_hi, sat_lo;
        logic     flip;
        logic [DIST_W-1:0] tq;
        ray_hit_t r;
        r.hit = 1'b0;
        r.tdist = '0;
        for (int i = 0; i < 3; i++)
        begin
            r.point[i] = '0;
            r.normal[i] = '0;
        end
        for (int i = 0; i < 3; i++)
        begin
            p0 = tr.c[i];
            p1 = tr.c[3 + i];
            p2 = tr.c[6 + i];
            ov = ray_org[i];
            dd[i] = ray_dir[i];
            sv[i] = ov - p0;
            e1[i] = p1 - p0;
            e2[i] = p2 - p0;
        end
        h[0] = cross_c(dd[1], dd[2], e2[1], e2[2]);
        h[1] = cross_c(dd[2], dd[0], e2[2], e2[0]);
        h[2] = cross_c(dd[0], dd[1], e2[0], e2[1]);
        a = e1[0] * h[0] + e1[1] * h[1] + e1[2] * h[2];
        flip = a < 0;
        absa = flip ? -a : a;
        if (absa * 10000 < (wide_t'(1) <<< (3 * FRAC)))
            return r;

        u = sv[0] * h[0] + sv[1] * h[1] + sv[2] * h[2];
        q[0] = cross_c(sv[1], sv[2], e1[1], e1[2]);
        q[1] = cross_c(sv[2], sv[0], e1[2], e1[0]);
        q[2] = cross_c(sv[0], sv[1], e1[0], e1[1]);
        v = dd[0] * q[0] + dd[1] * q[1] + dd[2] * q[2];
        t = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
        if (flip)
        begin
            u = -u;
            v = -v;
            t = -t;
        end
        mx = '0;
        mx[DIST_W-1:0] = ray_max;
        if (u < 0 || u > absa)
            return r;
        if (v < 0 || u + v > absa)
            return r;
        if (t < 0 || (t <<< FRAC) > mx * absa)
            return r;

        quo = (t <<< FRAC) / absa;
        tq = quo[DIST_W-1:0];
        r.hit = 1'b1;
        r.tdist = tq;

        // Hit point: floor of t times direction, then saturate.
        sat_hi = (wide_t'(1) <<< 31) - 1;
        sat_lo = -(wide_t'(1) <<< 31);
        for (int i = 0; i < 3; i++)
        begin
            pp = '0;
            pp[DIST_W-1:0] = tq;
            ov = ray_org[i];
            s = ((pp * dd[i]) >>> FRAC) + ov;
            if (s > sat_hi)
                s = sat_hi;
            if (s < sat_lo)
                s = sat_lo;
            r.point[i] = s[COORD_W-1:0];
        end

        // Unit normal, facing the ray origin.
        n[0] = cross_c(e1[1], e1[2], e2[1], e2[2]);
        n[1] = cross_c(e1[2], e1[0], e2[2], e2[0]);
        n[2] = cross_c(e1[0], e1[1], e2[0], e2[1]);
        nn = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
        if (nn == 0)
            return r;
        for (int i = 0; i < 3; i++)
        begin
            num = (n[i] * n[i]) <<< 28;
            quo = num / nn;
            cs = '0;
            cs[63:0] = isqrt64(quo[63:0]);
            if ((n[i] < 0) != flip)
                cs = -cs;
            r.normal[i] = cs[NORM_W-1:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Driver: register writes only when nothing is in flight, triangles otherwise.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cfg_we <= 1'b0;
            cfg_addr <= '0;
            cfg_wdata <= '0;
            for (int i = 0; i < 9; i++)
                vtx[i] <= '0;
            ray_org[0] = '0;
            ray_org[1] = '0;
            ray_org[2] = '0;
            ray_dir[0] = '0;
            ray_dir[1] = '0;
            ray_dir[2] = ONE;
            ray_max = '1;
        end
        else
        begin
            op_t op;
            bit  quiet;
            bit  we;
            we = 1'b0;
            if (start && !busy)
                expected_hits.push_back(trace_triangle(cur_tri));
            quiet = cycle_count > 1500 && cycle_count < 2300;
            if (start && busy)
            begin
                // Hold the item until the block takes it.
            end
            else if (pending_ops.size() == 0)
                start <= 1'b0;
            else if (pending_ops[0].kind == OP_CFG)
            begin
                start <= 1'b0;
                if (!start && expected_hits.size() == 0)
                begin
                    op = pending_ops.pop_front();
                    we = 1'b1;
                    cfg_addr <= op.addr;
                    cfg_wdata <= op.data;
                    case (op.addr)
                        REG_ORIGIN_X: ray_org[0] = op.data;
                        REG_ORIGIN_Y: ray_org[1] = op.data;
                        REG_ORIGIN_Z: ray_org[2] = op.data;
                        REG_DIR_X:    ray_dir[0] = op.data;
                        REG_DIR_Y:    ray_dir[1] = op.data;
                        REG_DIR_Z:    ray_dir[2] = op.data;
                        REG_MAX_DIST: ray_max = op.data[DIST_W-1:0];
                        default: ;
                    endcase
                end
            end
            else if (!quiet && $urandom_range(99) < 10)
                start <= 1'b0;
            else
            begin
                op = pending_ops.pop_front();
                cur_tri = op.facet;
                start <= 1'b1;
                for (int i = 0; i < 9; i++)
                    vtx[i] <= op.facet.c[i];
            end
            cfg_we <= we;
        end
    end

    // Monitor: every done strobe is one result transfer.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            ray_hit_t want;
            if (expected_hits.size() == 0)
            begin
                report_mismatch("unexpected result count", 1, 0);
            end
            else
            begin
                want = expected_hits.pop_front();
                if (hit !== want.hit)
                    report_mismatch("hit", hit, want.hit);
                if (distance !== want.tdist)
                    report_mismatch("distance", distance, want.tdist);
                if (point_x !== want.point[0])
                    report_mismatch("point_x", point_x, want.point[0]);
                if (point_y !== want.point[1])
                    report_mismatch("point_y", point_y, want.point[1]);
                if (point_z !== want.point[2])
                    report_mismatch("point_z", point_z, want.point[2]);
                if (normal_x !== want.normal[0])
                    report_mismatch("normal_x", normal_x, want.normal[0]);
                if (normal_y !== want.normal[1])
                    report_mismatch("normal_y", normal_y, want.normal[1]);
                if (normal_z !== want.normal[2])
                    report_mismatch("normal_z", normal_z, want.normal[2]);
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic add_cfg(input logic [CFG_ADDR_W-1:0] addr, input logic [COORD_W-1:0] data);
        op_t op;
        op.kind = OP_CFG;
        op.addr = addr;
        op.data = data;
        pending_ops.push_back(op);
    endtask

    task automatic add_ray(input int ox, input int oy, input int oz,
                           input int dx, input int dy, input int dz, input int mx);
        add_cfg(REG_ORIGIN_X, ox);
        add_cfg(REG_ORIGIN_Y, oy);
        add_cfg(REG_ORIGIN_Z, oz);
        add_cfg(REG_DIR_X, dx);
        add_cfg(REG_DIR_Y, dy);
        add_cfg(REG_DIR_Z, dz);
        add_cfg(REG_MAX_DIST, mx);
    endtask

    task automatic add_tri(input int a, input int b, input int c, input int d, input int e,
                           input int f, input int g, input int h, input int k);
        op_t op;
        op.kind = OP_TRI;
        op.facet.c = '{a, b, c, d, e, f, g, h, k};
        pending_ops.push_back(op);
    endtask

    function automatic int clamp32(input longint x);
        if (x > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (x < -64'sd2147483648)
            return 32'h8000_0000;
        return int'(x);
    endfunction

    // Triangles whose centroid lies on the ray, mostly hits, some stretched along x.
    task automatic add_aimed(input int ox, input int oy, input int oz,
                             input int dx, input int dy, input int dz);
        longint k, span;
        longint pnt [3];
        longint ea [3], eb [3];
        int     org [3], dir [3];
        org = '{ox, oy, oz};
        dir = '{dx, dy, dz};
        k = $urandom_range(40 * ONE, ONE / 4);
        span = ($urandom_range(3) == 0) ? (1 << 12) : (1 << 21);
        for (int i = 0; i < 3; i++)
        begin
            pnt[i] = longint'(org[i]) + ((k * longint'(dir[i])) >>> FRAC);
            ea[i] = longint'($urandom_range(2 * span)) - span;
            eb[i] = longint'($urandom_range(2 * span)) - span;
        end
        if ($urandom_range(4) == 0)
            eb[0] = eb[0] + span * 3;
        add_tri(clamp32(pnt[0] + ea[0]), clamp32(pnt[1] + ea[1]), clamp32(pnt[2] + ea[2]),
                clamp32(pnt[0] + eb[0]), clamp32(pnt[1] + eb[1]), clamp32(pnt[2] + eb[2]),
                clamp32(pnt[0] - ea[0] - eb[0]), clamp32(pnt[1] - ea[1] - eb[1]),
                clamp32(pnt[2] - ea[2] - eb[2]));
    endtask

    task automatic add_noise();
        add_tri($urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom);
    endtask

    // One ray setting followed by a batch of mostly aimed triangles.
    task automatic add_phase(input int ox, input int oy, input int oz, input int dx,
                             input int dy, input int dz, input int mx, input int count);
        add_ray(ox, oy, oz, dx, dy, dz, mx);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(9) < 8)
                add_aimed(ox, oy, oz, dx, dy, dz);
            else
                add_noise();
        end
    endtask

    function automatic int small_coord(input int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // Stimulus plan and end of run.
    initial
    begin
        int U;
        U = ONE;
        mismatches = 0;
        cycle_count = 0;
        stimulus_done = 0;

        // Reset ray: origin 0 looking along +z, unlimited distance.
        add_tri(-U, -U, 5 * U, 2 * U, -U, 5 * U, -U, 2 * U, 5 * U);
        add_tri(-U, -U, 5 * U, -U, 2 * U, 5 * U, 2 * U, -U, 5 * U);
        add_tri(-U, -U, -5 * U, 2 * U, -U, -5 * U, -U, 2 * U, -5 * U);
        add_tri(9 * U, -U, 5 * U, 12 * U, -U, 5 * U, 9 * U, 2 * U, 5 * U);
        add_tri(-U, 9 * U, 5 * U, 2 * U, 9 * U, 5 * U, -U, 12 * U, 5 * U);
        add_tri(0, 0, 3 * U, U, 0, 3 * U, 0, U, 3 * U);
        add_tri(-U, -U, 0, 2 * U, -U, 0, -U, 2 * U, 0);
        add_tri(U, U, U, U, U, U, U, U, U);
        add_tri(-U, 0, U, U, 0, U, 0, 0, 2 * U);
        add_tri(0, 0, U, 1, 0, U, 0, 1, U);
        add_tri(-300, -300, U, 600, -300, U, -300, 600, U);
        add_tri(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_tri(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        add_tri(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);

        // Distance limit at exactly the hit, then just short of it.
        add_cfg(REG_MAX_DIST, 5 * U);
        add_tri(-U, -U, 5 * U, 2 * U, -U, 5 * U, -U, 2 * U, 5 * U);
        add_tri(-U, -U, 5 * U + 1, 2 * U, -U, 5 * U + 1, -U, 2 * U, 5 * U + 1);
        add_cfg(REG_MAX_DIST, 0);
        add_tri(-U, -U, 5 * U, 2 * U, -U, 5 * U, -U, 2 * U, 5 * U);
        add_tri(-U, -U, 0, 2 * U, -U, 0, -U, 2 * U, 0);

        // Saturated hit points from a ray near the top of the range.
        add_cfg(REG_UNUSED, 32'hFFFF_FFFF);
        add_ray(32'h7FFF_0000, 32'h8000_FFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000, U, 32'h7FFF_FFFF);
        add_tri(32'h7FFF_0000, 32'h8000_FFFF, 40 * U, 32'h7FFF_0000, 32'h8000_FFFF + U, 41 * U,
                32'h7FFF_0000 - U, 32'h8000_FFFF, 41 * U);
        add_tri(32'h7FFF_0000 - U, 32'h8000_FFFF - U, 3 * U, 32'h7FFF_0000 + U / 2,
                32'h8000_FFFF - U, 3 * U, 32'h7FFF_0000 - U, 32'h8000_FFFF + U, 3 * U);

        // Random part: several ray settings, extremes among them.
        add_phase(0, 0, 0, 0, 0, U, 32'h7FFF_FFFF, 60);
        add_phase(small_coord(1 << 22), small_coord(1 << 22), small_coord(1 << 22),
                  small_coord(1 << 17), small_coord(1 << 17), small_coord(1 << 17),
                  100 * U, 70);
        add_phase(3 * U, -2 * U, U / 2, -U / 3, U / 5, U, 12 * U, 50);
        add_phase(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1,
                  32'h7FFF_FFFF, 40);
        add_phase(small_coord(1 << 20), small_coord(1 << 20), small_coord(1 << 20),
                  small_coord(1 << 16), small_coord(1 << 16), small_coord(1 << 16),
                  $urandom_range(32'h7FFF_FFFF), 60);
        add_phase(0, 0, 0, 1, -1, 1, 32'h7FFF_FFFF, 20);
        add_phase($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom_range(32'h7FFF_FFFF), 30);
        add_phase(-5 * U, 7 * U, -U, 2 * U, -U, -3 * U, 30 * U, 70);
        stimulus_done = 1;

        wait (pending_ops.size() == 0);
        @(posedge clk);
        wait (!start && expected_hits.size() == 0);
        repeat (DRAIN) @(posedge clk);
        if (mismatches == 0 && expected_hits.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### ray_triangle_intersect_unit.f
src/rti_pkg.sv
src/rti_mul.sv
src/rti_div.sv
src/rti_sqrt.sv
src/rti_delay.sv
src/ray_triangle_intersect_unit.sv
tb/sv/ray_triangle_intersect_unit_tb.sv
